// ===== rtl/dss_pkg.sv =====
// shared constants and types for the directional smoothing filter
// no dependencies; every other file in rtl imports this package
package dss_pkg;

    localparam int DSS_MAX_WIDTH = 1024;
    localparam int DSS_Q_DEPTH   = 4;

    localparam int CH_W    = 8;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 16;
    localparam int IMG_W_W = 11;
    localparam int IMG_H_W = 16;
    localparam int MIN_DIM = 3;

    localparam logic [IMG_W_W-1:0] RST_WIDTH  = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] RST_HEIGHT = IMG_H_W'(480);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index codes, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // channel positions inside a packed pixel
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    // result slots of one item, in output order
    localparam int SL_MAIN   = 0;
    localparam int SL_RIGHT  = 1;
    localparam int SL_BOTTOM = 2;
    localparam int SL_N      = 3;

    typedef logic [2:0][CH_W-1:0] t_px;

    typedef struct packed {
        logic               restart;
        logic [IMG_W_W-1:0] width;
        logic [IMG_H_W-1:0] height;
    } t_cfg;

    // one classified item: its results are built from these fields
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [SL_N-1:0]  sched;
        t_px              px_main;
        t_px              mid;
        t_px              cur;
    } t_job;

endpackage

// ===== rtl/dss_if.sv =====
// valid/ready channel interfaces for pixels in and results out
// depends on dss_pkg for field widths
interface dss_pix_if import dss_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] pix_red;
    logic [CH_W-1:0] pix_green;
    logic [CH_W-1:0] pix_blue;

    modport source(output valid, output pix_red, output pix_green, output pix_blue,
                   input ready);
    modport sink(input valid, input pix_red, input pix_green, input pix_blue,
                 output ready);
endinterface

interface dss_res_if import dss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic             run_last;

    modport source(output valid, output out_col, output out_row, output out_red,
                   output out_green, output out_blue, output run_last, input ready);
    modport sink(input valid, input out_col, input out_row, input out_red,
                 input out_green, input out_blue, input run_last, output ready);
endinterface

// ===== rtl/dss_front.sv =====
// front part: pixel intake, raster counters, line memory, 3x3 window, means
// and direction pick; emits one classified item per pixel. uses dss_pkg, dss_pix_if
module dss_front import dss_pkg::*; #(
    parameter int MAX_WIDTH = DSS_MAX_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    dss_pix_if.sink i_pix,
    input  logic i_q_ready,
    output logic o_push,
    output t_job o_job
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
    localparam int CXW = (WW > COL_W) ? WW : COL_W;
    localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);
    localparam logic [WW-1:0] MINW = WW'(MIN_DIM);
    localparam logic [IMG_H_W-1:0] MINH = IMG_H_W'(MIN_DIM);
    // floor(x/3) for x below 766 as (x*683)>>11
    localparam int DIV3_MUL = 683;
    localparam int DIV3_SH  = 11;
    localparam int PW       = 2 * CH_W + 4;

    typedef struct packed {
        t_px upper;
        t_px middle;
    } t_lines;

    function automatic logic [CH_W-1:0] f_mean3(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] p,
                                                input logic [CH_W-1:0] b);
        logic [CH_W+1:0] sum;
        logic [PW-1:0]   prod;
        sum  = (CH_W+2)'(a) + (CH_W+2)'(p) + (CH_W+2)'(b);
        prod = PW'(sum) * PW'(DIV3_MUL);
        return prod[DIV3_SH+CH_W-1:DIV3_SH];
    endfunction

    function automatic logic [CH_W-1:0] f_pick(input logic [CH_W-1:0] p,
                                               input logic [3:0][CH_W-1:0] m);
        logic [CH_W-1:0] best;
        logic [CH_W-1:0] bd;
        logic [CH_W-1:0] d;
        best = m[0];
        bd   = (m[0] > p) ? m[0] - p : p - m[0];
        for (int k = 1; k < 4; k++) begin
            d = (m[k] > p) ? m[k] - p : p - m[k];
            if (d < bd) begin
                best = m[k];
                bd   = d;
            end
        end
        return best;
    endfunction

    // frame geometry
    logic [WW-1:0]      w_ext, w_eff, w_m1, col_ext;
    logic [IMG_H_W-1:0] h_eff, h_m1;
    logic [CXW-1:0]     col_x;
    logic               col_last, row_last;

    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    logic adv, acc, s1_fire;

    // stage 1: accepted pixel plus line memory read
    t_lines            r_mem [MAX_WIDTH];
    t_lines            r_rd;
    logic              r_s1_v;
    t_px               r_s1_cur;
    logic [CW-1:0]     r_s1_col;
    logic [COL_W-1:0]  r_s1_col10;
    logic [ROW_W-1:0]  r_s1_row;
    logic [SL_N-1:0]   r_s1_sched;
    logic              r_s1_int;
    logic [SL_N-1:0]   n_sched;
    t_px               pix_in;

    // window: 0..2 column c-1, 3..5 column c-2, each top/middle/bottom
    t_px r_win [6];

    // stage 2: four direction means per channel
    logic              r_s2_v;
    t_px [3:0]         n_mean;
    t_px [3:0]         r_s2_mean;
    t_px               r_s2_ctr;
    t_px               r_s2_mid;
    t_px               r_s2_cur;
    logic [COL_W-1:0]  r_s2_col10;
    logic [ROW_W-1:0]  r_s2_row;
    logic [SL_N-1:0]   r_s2_sched;
    logic              r_s2_int;
    t_px               px_sel;

    always_comb begin
        w_ext    = WW'(i_cfg.width);
        w_eff    = (w_ext < MINW) ? MINW : ((w_ext > MAXW) ? MAXW : w_ext);
        w_m1     = w_eff - WW'(1);
        h_eff    = (i_cfg.height < MINH) ? MINH : i_cfg.height;
        h_m1     = h_eff - IMG_H_W'(1);
        col_ext  = WW'(r_col);
        col_x    = CXW'(r_col);
        col_last = (col_ext == w_m1);
        row_last = (r_row == h_m1);
    end

    assign adv         = !r_s2_v || i_q_ready;
    assign i_pix.ready = adv;
    assign acc         = i_pix.valid && adv;
    assign s1_fire     = adv && r_s1_v;
    assign pix_in      = {i_pix.pix_red, i_pix.pix_green, i_pix.pix_blue};

    // which results this pixel finishes
    always_comb begin
        n_sched            = '0;
        n_sched[SL_MAIN]   = (r_row != '0) && (r_col != '0);
        n_sched[SL_RIGHT]  = (r_row != '0) && col_last;
        n_sched[SL_BOTTOM] = row_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // line memory: one read at accept, one write as the item leaves stage 1
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd <= r_mem[r_col];
        end
        if (s1_fire) begin
            r_mem[r_s1_col] <= '{upper: r_rd.middle, middle: r_s1_cur};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= acc;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_cur   <= pix_in;
            r_s1_col   <= r_col;
            r_s1_col10 <= col_x[COL_W-1:0];
            r_s1_row   <= r_row;
            r_s1_sched <= n_sched;
            r_s1_int   <= (r_row > ROW_W'(1)) && (col_ext > WW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_fire) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= r_rd.upper;
            r_win[1] <= r_rd.middle;
            r_win[2] <= r_s1_cur;
        end
    end

    // column, row, diagonal, anti-diagonal around the center r_win[1]
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_mean[0][ch] = f_mean3(r_win[0][ch], r_win[1][ch], r_win[2][ch]);
            n_mean[1][ch] = f_mean3(r_win[4][ch], r_win[1][ch], r_rd.middle[ch]);
            n_mean[2][ch] = f_mean3(r_win[3][ch], r_win[1][ch], r_s1_cur[ch]);
            n_mean[3][ch] = f_mean3(r_rd.upper[ch], r_win[1][ch], r_win[5][ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s2_mean  <= n_mean;
            r_s2_ctr   <= r_win[1];
            r_s2_mid   <= r_rd.middle;
            r_s2_cur   <= r_s1_cur;
            r_s2_col10 <= r_s1_col10;
            r_s2_row   <= r_s1_row;
            r_s2_sched <= r_s1_sched;
            r_s2_int   <= r_s1_int;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            px_sel[ch] = f_pick(r_s2_ctr[ch], {r_s2_mean[3][ch], r_s2_mean[2][ch],
                                               r_s2_mean[1][ch], r_s2_mean[0][ch]});
        end
    end

    assign o_push        = adv && r_s2_v;
    assign o_job.col     = r_s2_col10;
    assign o_job.row     = r_s2_row;
    assign o_job.sched   = r_s2_sched;
    assign o_job.px_main = r_s2_int ? px_sel : r_s2_ctr;
    assign o_job.mid     = r_s2_mid;
    assign o_job.cur     = r_s2_cur;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        col_ext <= w_m1)
        else $error("column counter beyond row end");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h_m1)
        else $error("row counter beyond frame end");

endmodule

// ===== rtl/dss_fifo.sv =====
// short item queue between the front and back parts
// depends on dss_pkg for the item type
module dss_fifo import dss_pkg::*; #(
    parameter int DEPTH = DSS_Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_ready,
    output logic o_valid,
    output t_job o_data,
    input  logic i_pop
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    t_job           r_q [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CNW-1:0] r_cnt;

    assign o_ready = (r_cnt != CNW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != CNW'(DEPTH)) || i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");

endmodule

// ===== rtl/dss_back.sv =====
// back part: expands each queued item into its zero to three results
// and holds one result in an output register; uses dss_pkg, dss_res_if
module dss_back import dss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_job i_head,
    output logic o_pop,
    dss_res_if.source o_res
);

    logic [SL_N-1:0]  r_done;
    logic             r_ov;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_px              r_px;
    logic             r_last;

    logic [SL_N-1:0]  rem, sel, left;
    logic             load, emit;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    t_px              n_px;

    always_comb begin
        rem   = i_head.sched & ~r_done;
        sel   = rem & (~rem + SL_N'(1));
        left  = rem & ~sel;
        load  = !r_ov || o_res.ready;
        emit  = load && i_q_valid && (rem != '0);
        o_pop = load && i_q_valid && (left == '0);
        // window centre up-left of the item, right border, or bottom row
        if (sel[SL_MAIN]) begin
            n_col = i_head.col - COL_W'(1);
            n_row = i_head.row - ROW_W'(1);
            n_px  = i_head.px_main;
        end else if (sel[SL_RIGHT]) begin
            n_col = i_head.col;
            n_row = i_head.row - ROW_W'(1);
            n_px  = i_head.mid;
        end else begin
            n_col = i_head.col;
            n_row = i_head.row;
            n_px  = i_head.cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_done <= '0;
        end else begin
            if (load) begin
                r_ov <= emit;
            end
            if (o_pop) begin
                r_done <= '0;
            end else if (emit) begin
                r_done <= r_done | sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_px   <= n_px;
            r_last <= (left == '0);
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.out_col   = r_col;
    assign o_res.out_row   = r_row;
    assign o_res.out_red   = r_px[CH_RED];
    assign o_res.out_green = r_px[CH_GREEN];
    assign o_res.out_blue  = r_px[CH_BLUE];
    assign o_res.run_last  = r_last;

    a_done_in_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done & ~(i_q_valid ? i_head.sched : {SL_N{1'b0}})) == '0)
        else $error("result slot marked done outside the head item");

endmodule

// ===== rtl/directional_smoothing_3x3_rgb_top.sv =====
// top level of the 3x3 directional smoothing filter for rgb pixel streams
// depends on dss_pkg, dss_if, dss_front, dss_fifo, dss_back
//
// usage:
//   i_pix  - valid/ready sink of rgb pixels in raster order, one per item
//   o_res  - valid/ready source of finished pixels with column and row;
//            run_last marks the last result caused by one input pixel
//   apb    - image_width at byte 0, image_height at byte 4; a write also
//            restarts the frame at pixel (0, 0) and must come while idle
// path: a pixel passes stage 1, stage 2, the queue and the output
//   register; its later results follow one per cycle while o_res is ready
// throughput: one pixel per cycle while each pixel gives at most one
//   result and o_res is ready; pixels in the last column past row 0 or
//   the last row past column 0 give two or three; the single result port
//   sets the pace then, with a 4-item queue absorbing the short bursts
// reset: counters, window and registers (640 x 480) clear at once; the
//   line memory is not cleared, no result ever reads an unwritten entry
// stall: when o_res is held the output register keeps its item, the
//   queue fills, and only then does i_pix.ready drop
module directional_smoothing_3x3_rgb_top import dss_pkg::*; #(
    parameter int MAX_WIDTH = DSS_MAX_WIDTH,
    parameter int Q_DEPTH   = DSS_Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dss_pix_if.sink           i_pix,
    dss_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // configuration registers
    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;
    logic               cfg_wr;
    t_cfg               cfg;

    // front to queue to back
    logic push, q_ready, q_valid, pop;
    t_job job_in, job_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RST_WIDTH;
            r_img_h <= RST_HEIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_img_w <= pwdata[IMG_W_W-1:0];
                REG_HEIGHT: r_img_h <= pwdata[IMG_H_W-1:0];
                default:    r_img_w <= r_img_w;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(r_img_w);
            REG_HEIGHT: prdata = APB_DW'(r_img_h);
            default:    prdata = '0;
        endcase
    end

    // any write restarts the frame
    assign cfg.restart = cfg_wr;
    assign cfg.width   = r_img_w;
    assign cfg.height  = r_img_h;

    dss_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_pix    (i_pix),
        .i_q_ready(q_ready),
        .o_push   (push),
        .o_job    (job_in)
    );

    dss_fifo #(
        .DEPTH(Q_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (job_in),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .o_data (job_head),
        .i_pop  (pop)
    );

    dss_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_head   (job_head),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the rgb 3x3 directional smoothing filter
// uses dss_pkg, dss_if and directional_smoothing_3x3_rgb_top; predicts each finished
// pixel in software and checks the result stream and the apb registers against it
module testbench;
    import dss_pkg::*;

    // one finished output pixel as the block should report it
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        t_px              px;
        logic             last;
    } t_fin_pixel;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    dss_pix_if pix_bus ();
    dss_res_if res_bus ();

    directional_smoothing_3x3_rgb_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: two previous rows, 3x2 window, next input position
    t_px                line_up2 [DSS_MAX_WIDTH];
    t_px                line_up1 [DSS_MAX_WIDTH];
    t_px                win [6] = '{default: '0};
    int                 next_col = 0;
    int                 next_row = 0;
    logic [IMG_W_W-1:0] img_width = RST_WIDTH;
    logic [IMG_H_W-1:0] img_height = RST_HEIGHT;

    t_fin_pixel  awaited_pixels [$];
    t_fin_pixel  head;
    int unsigned mismatches = 0;

    // sender burst state
    int burst_left = 0;
    bit steady_send = 1'b0;

    // receiver stall pattern, cycling through four modes
    logic [9:0] rx_phase = '0;
    logic       rx_ready = 1'b0;

    assign res_bus.ready = rx_ready;

    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 10'd1;
        case (rx_phase[8:7])
            2'd0: rx_ready <= 1'b1;
            2'd1: rx_ready <= ($urandom_range(0, 3) != 0);
            2'd2: rx_ready <= (rx_phase % 3 == 0);
            default: rx_ready <= rx_phase[4];
        endcase
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (awaited_pixels.size() == 0) begin
                $error("unexpected result: col %0d row %0d", res_bus.out_col,
                       res_bus.out_row);
                mismatches++;
            end else begin
                head = awaited_pixels.pop_front();
                check_field("out_col", 32'(head.col), 32'(res_bus.out_col));
                check_field("out_row", 32'(head.row), 32'(res_bus.out_row));
                check_field("out_red", 32'(head.px[CH_RED]), 32'(res_bus.out_red));
                check_field("out_green", 32'(head.px[CH_GREEN]), 32'(res_bus.out_green));
                check_field("out_blue", 32'(head.px[CH_BLUE]), 32'(res_bus.out_blue));
                check_field("run_last", 32'(head.last), 32'(res_bus.run_last));
            end
        end
    end

    function automatic int active_width();
        int v;
        v = int'(img_width);
        if (v > DSS_MAX_WIDTH) v = DSS_MAX_WIDTH;
        if (v < MIN_DIM) v = MIN_DIM;
        return v;
    endfunction

    function automatic int active_height();
        int v;
        v = int'(img_height);
        if (v < MIN_DIM) v = MIN_DIM;
        return v;
    endfunction

    // line mean closest to the center; ties keep the earlier direction
    function automatic logic [CH_W-1:0] best_mean(t_px center, t_px nb [8], int ch);
        int p, m, d, best, best_d, k;
        p = int'(center[ch]);
        best = 0;
        best_d = 0;
        for (k = 0; k < 4; k++) begin
            m = (int'(nb[2*k][ch]) + p + int'(nb[2*k+1][ch])) / 3;
            d = (m > p) ? m - p : p - m;
            if (k == 0 || d < best_d) begin
                best = m;
                best_d = d;
            end
        end
        return CH_W'(best);
    endfunction

    function automatic t_fin_pixel finished(int col, int row, t_px px);
        t_fin_pixel f;
        f.col = COL_W'(col);
        f.row = ROW_W'(row);
        f.px = px;
        f.last = 1'b0;
        return f;
    endfunction

    // advance the predictor by one accepted pixel and queue what it finishes
    function automatic void filter_pixel(t_px cur);
        int w, h, c, r, n, ch, i;
        t_px top, mid, center;
        t_px nb [8];
        t_fin_pixel res [3];
        w = active_width();
        h = active_height();
        c = next_col;
        r = next_row;
        top = line_up2[c];
        mid = line_up1[c];
        n = 0;
        if (r >= 1 && c >= 1) begin
            center = win[1];
            if (r >= 2 && c >= 2) begin
                // pairs along column, row, diagonal, anti-diagonal
                nb = '{win[0], win[2], win[4], mid, win[3], cur, top, win[5]};
                for (ch = 0; ch < 3; ch++) center[ch] = best_mean(win[1], nb, ch);
            end
            res[n] = finished(c - 1, r - 1, center);
            n++;
        end
        if (r >= 1 && c == w - 1) begin
            res[n] = finished(c, r - 1, mid);
            n++;
        end
        if (r == h - 1) begin
            res[n] = finished(c, r, cur);
            n++;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (i = 0; i < n; i++) awaited_pixels.push_back(res[i]);

        line_up2[c] = mid;
        line_up1[c] = cur;
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = top;
        win[1] = mid;
        win[2] = cur;
        if (c + 1 >= w) begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
        end
    endfunction

    function automatic t_px make_pixel(t_px base, int spread);
        t_px px;
        int v, ch;
        px = 24'($urandom);
        if (spread != 0) begin
            for (ch = 0; ch < 3; ch++) begin
                v = int'(base[ch]) + int'($urandom_range(0, 2 * spread)) - spread;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                px[ch] = CH_W'(v);
            end
        end
        return px;
    endfunction

    // one item on the pixel channel, with random gaps between bursts
    task automatic send_pixel(t_px px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = steady_send ? 0 : $urandom_range(0, 6);
            repeat (gap) begin
                @(negedge i_clk);
                pix_bus.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        pix_bus.valid     <= 1'b1;
        pix_bus.pix_red   <= px[CH_RED];
        pix_bus.pix_green <= px[CH_GREEN];
        pix_bus.pix_blue  <= px[CH_BLUE];
        do @(posedge i_clk); while (pix_bus.ready !== 1'b1);
        filter_pixel(px);
    endtask

    // spread 0 gives noise, otherwise pixels scatter around one base color
    task automatic stream_pixels(int count, int spread);
        t_px base;
        base = 24'($urandom);
        repeat (count) send_pixel(make_pixel(base, spread));
    endtask

    // stop sending and wait for every awaited result plus the pipeline tail
    task automatic drain_results();
        int waited;
        @(negedge i_clk);
        pix_bus.valid <= 1'b0;
        waited = 0;
        while (awaited_pixels.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        if (awaited_pixels.size() != 0) begin
            $error("%0d results never arrived", awaited_pixels.size());
            mismatches++;
            awaited_pixels.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic read_reg(logic idx, logic [31:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({idx, 2'b00});
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        check_field(idx == REG_WIDTH ? "image_width" : "image_height", want, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // register write restarts the frame, then read back the masked value
    task automatic write_reg(logic idx, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx == REG_WIDTH) img_width = data[IMG_W_W-1:0];
        else img_height = data[IMG_H_W-1:0];
        foreach (win[i]) win[i] = '0;
        next_col = 0;
        next_row = 0;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_reg(idx, idx == REG_WIDTH ? 32'(img_width) : 32'(img_height));
    endtask

    // defaults 640 x 480; the first pixels of row 0 finish nothing
    task automatic test_reset_values();
        read_reg(REG_WIDTH, 32'(RST_WIDTH));
        read_reg(REG_HEIGHT, 32'(RST_HEIGHT));
        stream_pixels(12, 4);
        drain_results();
    endtask

    // all-zero and all-one channels; width written with junk above bit 10,
    // height zero so it clamps to three rows
    task automatic test_extreme_pixels();
        t_px frame [9] = '{24'hFFFFFF, 24'h000000, 24'hFF00FF,
                           24'h00FF00, 24'h808080, 24'hFFFFFF,
                           24'h0000FF, 24'hFFFFFF, 24'h000000};
        write_reg(REG_WIDTH, 32'hFFFF_F803);
        write_reg(REG_HEIGHT, 32'hFFFF_0000);
        foreach (frame[i]) send_pixel(frame[i]);
        drain_results();
    endtask

    // red ties column against row, green ties diagonal against anti-diagonal,
    // blue prefers the diagonal; width 0 and height 2 both clamp to 3
    task automatic test_tie_breaks();
        t_px frame [9] = '{24'h006133, 24'h60FFFF, 24'hFF6800,
                           24'h660031, 24'h646432, 24'h680032,
                           24'hFF66FF, 24'h62FF00, 24'h006232};
        write_reg(REG_WIDTH, 32'd0);
        write_reg(REG_HEIGHT, 32'd2);
        foreach (frame[i]) send_pixel(frame[i]);
        drain_results();
    endtask

    // a write in the middle of a frame starts over at pixel (0, 0)
    task automatic test_frame_restart();
        write_reg(REG_WIDTH, 32'd5);
        write_reg(REG_HEIGHT, 32'd4);
        stream_pixels(13, 0);
        drain_results();
        write_reg(REG_WIDTH, 32'd5);
        stream_pixels(20, 2);
        drain_results();
    endtask

    // mostly small frames, some broken off early, some back to back
    task automatic test_random_frames();
        int w, h, frames, count, spread, sent;
        sent = 0;
        while (sent < 100) begin
            if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 2);
            else if ($urandom_range(0, 5) == 0) w = $urandom_range(9, 40);
            else w = $urandom_range(3, 8);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            write_reg(REG_WIDTH, ($urandom & ~32'h7FF) | 32'(w));
            write_reg(REG_HEIGHT, ($urandom & ~32'hFFFF) | 32'(h));
            steady_send = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 2);
            repeat (frames) begin
                count = active_width() * active_height();
                // broken frame: cut short, the next write restarts it
                if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count - 1);
                // keep the total item count near its budget
                if (count > 100 - sent) count = 100 - sent;
                spread = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                stream_pixels(count, spread);
                sent += count;
            end
            drain_results();
        end
        steady_send = 1'b0;
    endtask

    // tallest frame register, only the first rows are sent
    task automatic test_tall_frame();
        write_reg(REG_WIDTH, 32'd3);
        write_reg(REG_HEIGHT, 32'd65535);
        stream_pixels(30, 0);
        drain_results();
    endtask

    // all width bits set clamps to the widest line; the start of row 0 only
    task automatic test_wide_frame();
        write_reg(REG_WIDTH, 32'd2047);
        write_reg(REG_HEIGHT, 32'd3);
        stream_pixels(12, 2);
        stream_pixels(12, 0);
        drain_results();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        pix_bus.valid     <= 1'b0;
        pix_bus.pix_red   <= '0;
        pix_bus.pix_green <= '0;
        pix_bus.pix_blue  <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_extreme_pixels();
        test_tie_breaks();
        test_frame_restart();
        test_random_frames();
        test_tall_frame();
        test_wide_frame();
        drain_results();

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
